// ----- design/factor_marginalize_sum_max_core_assert.svh -----
// assertion macros shared by the core
`ifndef FACTOR_MARGINALIZE_SUM_MAX_CORE_ASSERT_SVH
`define FACTOR_MARGINALIZE_SUM_MAX_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define FMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fms assertion failed");
// next-cycle implication, checked outside reset
`define FMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fms assertion failed");
`else
`define FMS_ASSERT_NOW(lbl, ante, cons)
`define FMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/fms_pkg.sv -----
package fms_pkg;

    // field widths
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int STRIDE_W   = 11;
    localparam int CARD_W     = 5;
    localparam int BEST_W     = 4;
    // walked addresses stay below 2**17 for every index, stride and cardinality
    localparam int ADDR_W     = 17;
    // sum of up to 31 entries
    localparam int ACC_W      = VAL_W + CARD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // reduce modes
    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    // saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic                    operation;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [BEST_W-1:0]       best_state;
        logic                    fault;
    } res_t;

    // table access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } tbl_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BASE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// ----- design/fms_mod.sv -----
module fms_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fms_pkg::IDX_W-1:0]     dividend,
    input  logic [fms_pkg::STRIDE_W-1:0]  divisor,
    output logic                          done,
    output logic [fms_pkg::STRIDE_W-1:0]  remainder
);
    import fms_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    work_reg, work_next;
    logic [STRIDE_W-1:0] rem_reg, rem_next;
    logic [STRIDE_W-1:0] div_reg, div_next;
    logic [STRIDE_W:0]   shifted;
    logic [STRIDE_W+1:0] diff;

    // one restoring step per cycle, dividend bits enter msb first
    always_comb
    begin
        shifted   = {rem_reg, work_reg[IDX_W-1]};
        diff      = {1'b0, shifted} - {2'b00, div_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(IDX_W);
            work_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            work_next = {work_reg[IDX_W-2:0], 1'b0};
            rem_next  = diff[STRIDE_W+1] ? shifted[STRIDE_W-1:0] : diff[STRIDE_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/fms_table.sv -----
module fms_table #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fms_pkg::tbl_cmd_t          tcmd,
    output logic [fms_pkg::VAL_W-1:0]  rd_data,
    output logic                       clearing
);
    import fms_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             clr_reg, clr_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;

    // zeroing sweep after reset, one entry a cycle
    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // write port
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (tcmd.wr_en)
        begin
            mem[tcmd.wr_addr[AW-1:0]] <= tcmd.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (tcmd.rd_en)
        begin
            rd_data_reg <= mem[tcmd.rd_addr[AW-1:0]];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_reg;

endmodule

// ----- design/factor_marginalize_sum_max_core.sv -----
// channel   direction  beat marked by       payload
// command   in         start && !busy       cmd (operation, index, value)
// result    out        done (one cycle)     res (result_value, best_state, fault)
// config    in         cfg_we               cfg_index, cfg_data
//
// a write beat's entry is stored at the accepting edge
// a query runs from accept to done through the remainder unit, the base address,
// the walk at one table read a cycle, the fold of the last beat, then drain and the
// result register; busy drops as done rises
// after reset the table is zeroed with busy high
// results cannot be stalled; done pulses for one cycle per query
`include "factor_marginalize_sum_max_core_assert.svh"

module factor_marginalize_sum_max_core #(
    parameter int TABLE_DEPTH     = 1024,
    parameter int MAX_CARDINALITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  fms_pkg::cmd_t                     cmd,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [fms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output fms_pkg::res_t                     res
);
    import fms_pkg::*;

    localparam int PROD_W = IDX_W + CARD_W;

    state_t state_reg, state_next;

    logic [STRIDE_W-1:0]     stride_reg;
    logic [CARD_W-1:0]       card_reg;
    logic                    mode_reg;

    logic                    accept;
    logic                    clearing;
    logic                    div_done;
    logic [STRIDE_W-1:0]     rem;
    logic [VAL_W-1:0]        rd_data;
    tbl_cmd_t                tcmd;

    logic [STRIDE_W-1:0]     s_eff;
    logic [CARD_W-1:0]       c_eff;
    logic [IDX_W-1:0]        qs;
    logic [PROD_W-1:0]       prod;

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [CARD_W-1:0]       k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [BEST_W-1:0]       best_reg, best_next;
    logic                    fault_reg, fault_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    rd_oob_reg, rd_oob_next;
    logic [CARD_W-1:0]       rd_k_reg, rd_k_next;
    logic                    done_reg, done_next;
    res_t                    res_reg, res_next;
    logic signed [ACC_W-1:0] v_ext;
    logic                    walk_more;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE) || clearing;

    // effective stride and cardinality
    assign s_eff = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
    assign c_eff = (int'(card_reg) > MAX_CARDINALITY) ? CARD_W'(MAX_CARDINALITY) : card_reg;

    // quotient times stride equals index minus remainder
    assign qs   = idx_reg - rem[IDX_W-1:0];
    assign prod = PROD_W'(qs) * PROD_W'(c_eff);

    assign walk_more = (k_reg < c_eff);

    fms_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (cmd.operation == OP_QUERY)),
        .dividend  (cmd.index),
        .divisor   (s_eff),
        .done      (div_done),
        .remainder (rem)
    );

    fms_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .tcmd     (tcmd),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.operation == OP_QUERY))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:  state_next = ST_WALK;
            ST_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and table access
    always_comb
    begin
        tcmd.wr_en   = accept && (cmd.operation == OP_WRITE)
                       && (ADDR_W'(cmd.index) < ADDR_W'(TABLE_DEPTH));
        tcmd.wr_addr = ADDR_W'(cmd.index);
        tcmd.wr_data = cmd.value;
        tcmd.rd_en   = 1'b0;
        tcmd.rd_addr = addr_reg;

        idx_next     = idx_reg;
        addr_next    = addr_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        best_next    = best_reg;
        fault_next   = fault_reg;
        rd_pend_next = 1'b0;
        rd_oob_next  = rd_oob_reg;
        rd_k_next    = rd_k_reg;
        done_next    = 1'b0;
        res_next     = res_reg;

        v_ext = rd_oob_reg ? '0 : ACC_W'($signed(rd_data));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = cmd.index;
                end
            end
            ST_BASE:
            begin
                addr_next  = ADDR_W'(rem) + ADDR_W'(prod);
                k_next     = '0;
                acc_next   = (mode_reg == MODE_MAX) ? SAT_LO : '0;
                best_next  = '0;
                fault_next = 1'b0;
            end
            ST_WALK:
            begin
                if (walk_more)
                begin
                    tcmd.rd_en   = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_oob_next  = (addr_reg >= ADDR_W'(TABLE_DEPTH));
                    rd_k_next    = k_reg;
                    addr_next    = addr_reg + ADDR_W'(s_eff);
                    k_next       = k_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                if (acc_reg > SAT_HI)
                begin
                    res_next.result_value = SAT_HI[VAL_W-1:0];
                end
                else if (acc_reg < SAT_LO)
                begin
                    res_next.result_value = SAT_LO[VAL_W-1:0];
                end
                else
                begin
                    res_next.result_value = acc_reg[VAL_W-1:0];
                end
                res_next.best_state = (mode_reg == MODE_MAX) ? best_reg : '0;
                res_next.fault      = fault_reg;
            end
            default:
            begin
            end
        endcase

        // fold in the beat read in the previous cycle
        if (rd_pend_reg)
        begin
            fault_next = fault_reg || rd_oob_reg;
            if (mode_reg == MODE_MAX)
            begin
                if (acc_reg <= v_ext)
                begin
                    acc_next  = v_ext;
                    best_next = rd_k_reg[BEST_W-1:0];
                end
            end
            else
            begin
                acc_next = acc_reg + v_ext;
            end
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            stride_reg  <= STRIDE_W'(1);
            card_reg    <= CARD_W'(2);
            mode_reg    <= MODE_SUM;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                    CFG_CARD:   card_reg   <= cfg_data[CARD_W-1:0];
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        best_reg   <= best_next;
        fault_reg  <= fault_next;
        rd_oob_reg <= rd_oob_next;
        rd_k_reg   <= rd_k_next;
        res_reg    <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

    // checks
    `FMS_ASSERT_NEXT(a_done_after_finish, state_reg == ST_DONE, done)
    `FMS_ASSERT_NOW(a_done_from_finish, done, $past(state_reg) == ST_DONE)
    `FMS_ASSERT_NOW(a_read_from_walk, rd_pend_reg, $past(state_reg) == ST_WALK)
    `FMS_ASSERT_NOW(a_sum_best_zero, done && (mode_reg == MODE_SUM), res.best_state == '0)
    `FMS_ASSERT_NOW(a_no_write_in_query, state_reg != ST_IDLE, !tcmd.wr_en)

endmodule

// ----- sim/factor_marginalize_sum_max_core_tb.sv -----
module factor_marginalize_sum_max_core_tb;
    import fms_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int MAX_CARD  = 16;
    localparam int LIMIT     = 400000;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    // register index that selects nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        cmd_t                   beat;
        bit                     typed;
        res_t                   want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    cmd_t                   cmd;
    logic                   busy;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    res_t                   res;

    // predictor state
    logic signed [VAL_W-1:0] entry_store [DEPTH];
    logic [STRIDE_W-1:0]     cur_stride;
    logic [CARD_W-1:0]       cur_card;
    logic                    cur_mode;
    res_t                    pending_results [$];
    dir_row_t                dir_rows [$];

    int error_count;
    int cycle_count;
    int sender_idle_pct;
    int writes_sent;
    int queries_sent;
    int results_seen;
    int reg_writes;

    factor_marginalize_sum_max_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .res       (res)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic res_t mk_res(input logic [VAL_W-1:0] v, input int best,
                                    input logic flt);
        res_t r;
        r.result_value = v;
        r.best_state   = BEST_W'(best);
        r.fault        = flt;
        return r;
    endfunction

    // effective stride and state count after the zero / saturation rules
    function automatic int unsigned eff_stride();
        return (cur_stride == 0) ? 1 : cur_stride;
    endfunction

    function automatic int unsigned eff_card();
        return (cur_card > MAX_CARD) ? MAX_CARD : cur_card;
    endfunction

    // sum or max over the states of the eliminated variable
    function automatic res_t reduce_entry(input logic [IDX_W-1:0] idx);
        int unsigned s;
        int unsigned c;
        int unsigned base;
        int unsigned addr;
        longint      acc;
        longint      v;
        res_t        r;
        s = eff_stride();
        c = eff_card();
        base = (idx % s) + (idx / s) * s * c;
        acc = (cur_mode == MODE_MAX) ? VAL_MIN : 0;
        r.best_state = '0;
        r.fault = 1'b0;
        for (int k = 0; k < c; k++)
        begin
            addr = base + k * s;
            if (addr < DEPTH)
                v = longint'(entry_store[addr]);
            else
            begin
                v = 0;
                r.fault = 1'b1;
            end
            if (cur_mode == MODE_MAX)
            begin
                // ties go to the later state
                if (acc <= v)
                begin
                    acc = v;
                    r.best_state = BEST_W'(k);
                end
            end
            else
                acc += v;
        end
        if (acc > VAL_MAX)
            acc = VAL_MAX;
        if (acc < VAL_MIN)
            acc = VAL_MIN;
        r.result_value = acc[VAL_W-1:0];
        return r;
    endfunction

    // true when every walked address of this query lands in the table
    function automatic bit walk_in_range(input logic [IDX_W-1:0] idx);
        int unsigned s;
        int unsigned c;
        int unsigned last;
        s = eff_stride();
        c = eff_card();
        if (c == 0)
            return 1'b1;
        last = (idx % s) + (idx / s) * s * c + (c - 1) * s;
        return last < DEPTH;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VAL_W'($signed($urandom_range(4)) - 2);
            3: return {$urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // mostly in-range queries, the rest anywhere
    function automatic logic [IDX_W-1:0] pick_query_index();
        logic [IDX_W-1:0] idx;
        idx = IDX_W'($urandom);
        if ($urandom_range(99) < 75)
        begin
            for (int t = 0; t < 12; t++)
            begin
                if ($urandom_range(1))
                    idx = IDX_W'($urandom_range(
                              DEPTH / ((eff_card() == 0) ? 1 : eff_card())));
                else
                    idx = IDX_W'($urandom);
                if (walk_in_range(idx))
                    break;
            end
        end
        return idx;
    endfunction

    // register write once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                             input logic [CFG_DATA_W-1:0] rdata);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= rdata;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (ridx)
            CFG_STRIDE: cur_stride = rdata[STRIDE_W-1:0];
            CFG_CARD:   cur_card   = rdata[CARD_W-1:0];
            CFG_MODE:   cur_mode   = rdata[0];
            default:    ;
        endcase
        reg_writes++;
    endtask

    // one command beat, with optional sender gaps ahead of it
    task automatic send_beat(input cmd_t c, input bit typed, input res_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // book the beat as accepted
        if (c.operation == OP_WRITE)
        begin
            entry_store[c.index] = c.value;
            writes_sent++;
        end
        else
        begin
            pending_results.push_back(typed ? want : reduce_entry(c.index));
            queries_sent++;
        end
    endtask

    function automatic void add_cmd(input logic op, input int idx, input logic [VAL_W-1:0] v,
                                    input bit typed, input res_t want);
        dir_row_t row;
        row.kind = ROW_CMD;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.beat.operation = op;
        row.beat.index = IDX_W'(idx);
        row.beat.value = v;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] ridx, input int data);
        dir_row_t row;
        row.kind = ROW_CFG;
        row.reg_idx = ridx;
        row.reg_data = CFG_DATA_W'(data);
        row.beat = '0;
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endfunction

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result beat with no query waiting");
            else
            begin
                want = pending_results.pop_front();
                if (res.result_value !== want.result_value)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              res.result_value, want.result_value));
                if (res.best_state !== want.best_state)
                    report_mismatch($sformatf("best_state %0d, expected %0d",
                                              res.best_state, want.best_state));
                if (res.fault !== want.fault)
                    report_mismatch($sformatf("fault %b, expected %b",
                                              res.fault, want.fault));
            end
        end
    end

    initial
    begin
        cmd_t c;
        res_t none;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] sdata;
        logic [CARD_W-1:0] cdata;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        writes_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        reg_writes = 0;
        none = '0;
        foreach (entry_store[i])
            entry_store[i] = '0;
        cur_stride = STRIDE_W'(1);
        cur_card = CARD_W'(2);
        cur_mode = MODE_SUM;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: cleared table, saturation, ties, out-of-range walks
        add_cmd(OP_QUERY, 0,    32'h1234_5678, 1, mk_res(32'h0, 0, 1'b0));
        add_cmd(OP_QUERY, 1023, 32'hFFFF_FFFF, 1, mk_res(32'h0, 0, 1'b1));
        add_cmd(OP_WRITE, 0,    32'h7FFF_FFFF, 0, none);
        add_cmd(OP_WRITE, 1,    32'h7FFF_FFFF, 0, none);
        add_cmd(OP_QUERY, 0,    32'h0,         1, mk_res(32'h7FFF_FFFF, 0, 1'b0));
        add_cmd(OP_WRITE, 2,    32'h8000_0000, 0, none);
        add_cmd(OP_WRITE, 3,    32'h8000_0000, 0, none);
        add_cmd(OP_QUERY, 1,    32'h0,         1, mk_res(32'h8000_0000, 0, 1'b0));
        add_cmd(OP_WRITE, 1023, 32'hFFFF_FFFF, 0, none);
        add_cmd(OP_QUERY, 511,  32'h0,         0, none);
        add_cfg(CFG_MODE, MODE_MAX);
        add_cmd(OP_QUERY, 0,    32'h0,         1, mk_res(32'h7FFF_FFFF, 1, 1'b0));
        add_cmd(OP_QUERY, 1,    32'h0,         1, mk_res(32'h8000_0000, 1, 1'b0));
        add_cmd(OP_QUERY, 1023, 32'h0,         1, mk_res(32'h0, 1, 1'b1));
        add_cfg(CFG_CARD, 16);
        add_cmd(OP_QUERY, 1,    32'h0,         1, mk_res(32'h0, 15, 1'b0));
        add_cfg(CFG_CARD, 0);
        add_cmd(OP_QUERY, 5,    32'h0,         1, mk_res(32'h8000_0000, 0, 1'b0));
        add_cfg(CFG_MODE, MODE_SUM);
        add_cmd(OP_QUERY, 5,    32'h0,         1, mk_res(32'h0, 0, 1'b0));
        add_cfg(CFG_STRIDE, 0);
        add_cfg(CFG_CARD, 31);
        add_cmd(OP_QUERY, 0,    32'h0,         0, none);
        add_cfg(CFG_STRIDE, 2047);
        add_cfg(CFG_CARD, 16);
        add_cfg(CFG_MODE, MODE_MAX);
        add_cmd(OP_QUERY, 1023, 32'h0,         0, none);
        add_cmd(OP_QUERY, 0,    32'h0,         0, none);
        add_cfg(CFG_STRIDE, 1024);
        add_cfg(CFG_CARD, 1);
        add_cmd(OP_QUERY, 1023, 32'h0,         0, none);
        add_cfg(CFG_UNUSED, 2047);
        add_cmd(OP_QUERY, 0,    32'h0,         0, none);

        sender_idle_pct = 17;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            else
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        // random part: three sender idle settings, fresh registers per segment
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 55 : 0;
            for (int seg = 0; seg < 14; seg++)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0, 1, 2, 3, 4: sdata = CFG_DATA_W'($urandom_range(1, 4));
                    5:             sdata = CFG_DATA_W'(0);
                    6:             sdata = CFG_DATA_W'(1024);
                    7:             sdata = CFG_DATA_W'(2047);
                    default:       sdata = CFG_DATA_W'($urandom);
                endcase
                write_reg(CFG_STRIDE, sdata);
                pick = $urandom_range(9);
                case (pick)
                    0, 1, 2, 3, 4, 5: cdata = CARD_W'($urandom_range(1, 16));
                    6:                cdata = CARD_W'(0);
                    7:                cdata = CARD_W'(16);
                    8:                cdata = CARD_W'(31);
                    default:          cdata = CARD_W'($urandom_range(17, 31));
                endcase
                write_reg(CFG_CARD, {6'($urandom), cdata});
                write_reg(CFG_MODE, {10'($urandom), 1'($urandom)});
                repeat (40)
                begin
                    c.operation = $urandom_range(1) ? OP_QUERY : OP_WRITE;
                    c.value = pick_value();
                    if (c.operation == OP_WRITE)
                        c.index = IDX_W'($urandom);
                    else
                        c.index = pick_query_index();
                    send_beat(c, 1'b0, none);
                end
            end
        end

        // drain
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d table writes, %0d reduced-entry queries, %0d results checked",
                 writes_sent, queries_sent, results_seen);
        $display("over %0d register writes and three sender gap rates, %0d mismatches",
                 reg_writes, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
